// ===== hw/rtl/gtpc_pkg.sv =====
package gtpc_pkg;

  // Heading width in bits.
  localparam int HEADING_BITS = 16;

  // Commands carried by an input item.
  localparam logic [1:0] CMD_START  = 2'd0;
  localparam logic [1:0] CMD_SAMPLE = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // Controller phases.
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_TURN  = 2'd1;
  localparam logic [1:0] PH_BRAKE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIRROR_TURN = 2'd0;
  localparam logic [1:0] REG_MIN_DRIVE   = 2'd1;
  localparam logic [1:0] REG_BRAKE_DRIVE = 2'd2;
  localparam logic [1:0] REG_BRAKE_TICKS = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [6:0] MIN_DRIVE_RST   = 7'd60;
  localparam logic [6:0] BRAKE_DRIVE_RST = 7'd60;
  localparam logic [7:0] BRAKE_TICKS_RST = 8'd5;

  // Gain schedule in Q8, truncated: 3.5, 1.8, 1.2 and 0.8.
  localparam logic [9:0] GAIN_3P5 = 10'd896;
  localparam logic [9:0] GAIN_1P8 = 10'd460;
  localparam logic [9:0] GAIN_1P2 = 10'd307;
  localparam logic [9:0] GAIN_0P8 = 10'd204;

  // Start error magnitudes above which the next lower gain applies.
  localparam int ERR_LIMIT_LOW  = 110;
  localparam int ERR_LIMIT_MID  = 150;
  localparam int ERR_LIMIT_HIGH = 180;

  // Largest drive magnitude.
  localparam int DRIVE_MAX = 127;

  typedef struct packed {
    logic [1:0]                     command;
    logic signed [HEADING_BITS-1:0] setpoint;
    logic signed [HEADING_BITS-1:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] left_drive;
    logic signed [7:0] right_drive;
    logic              busy_res;
    logic              finished;
  } out_item_t;

  typedef struct packed {
    logic       mirror_turn;
    logic [6:0] min_drive;
    logic [6:0] brake_drive;
    logic [7:0] brake_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0]                   phase;
    logic signed [HEADING_BITS:0] target;
    logic [9:0]                   gain_q8;
    logic                         turn_clockwise;
    logic [7:0]                   brake_remaining;
    logic signed [7:0]            left_hold;
    logic signed [7:0]            right_hold;
  } state_t;

endpackage

// ===== hw/rtl/gyro_turn_p_control.sv =====
// Each input item is held in the input register, and its result then moves
// into the result register, which offers it until out_ready takes it.
// Throughput: one item per cycle; the input stalls only while the input
// register and the result register both hold an item and the result waits.
// Reset (rst_n low at a clock edge) clears the controller to idle with zero
// drive and restores the configuration defaults.
module gyro_turn_p_control import gtpc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  cfg_t      cfg;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  in_item_t  s1_item_r;
  state_t    st_r;
  state_t    st_nxt;
  out_item_t result;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_item_t out_item_r;
  logic      s1_adv;
  logic      in_xfer;

  gtpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gtpc_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (s1_item_r),
    .st_nxt (st_nxt),
    .result (result)
  );

  // Flow control between the input register and the result register.
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and controller state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // An idle controller holds no drive.
  a_idle_no_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == PH_IDLE) |-> (st_r.left_hold == 8'sd0 && st_r.right_hold == 8'sd0))
    else $error("idle phase with nonzero hold drive");

  // Left and right drive always oppose each other.
  a_drive_opposed: assert property (@(posedge clk) disable iff (!rst_n)
    (8'(st_r.left_hold + st_r.right_hold) == 8'd0))
    else $error("left and right hold drive do not oppose");

  // A finishing result stops the motors and drops busy.
  a_finish_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.finished) |->
      (!out_data.busy_res && out_data.left_drive == 8'sd0))
    else $error("finished result with drive or busy set");

  // Input stalls only when both stages hold an item and the result waits.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("input stalled without a full pipeline");

  // State changes only when an item moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(st_r))
    else $error("controller state changed without an item");

endmodule

// ===== hw/rtl/gtpc_cfg.sv =====
module gtpc_cfg import gtpc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Register file write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MIRROR_TURN: cfg_nxt.mirror_turn = cfg_wdata[0];
        REG_MIN_DRIVE:   cfg_nxt.min_drive   = cfg_wdata[6:0];
        REG_BRAKE_DRIVE: cfg_nxt.brake_drive = cfg_wdata[6:0];
        REG_BRAKE_TICKS: cfg_nxt.brake_ticks = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mirror_turn <= 1'b0;
      cfg_r.min_drive   <= MIN_DRIVE_RST;
      cfg_r.brake_drive <= BRAKE_DRIVE_RST;
      cfg_r.brake_ticks <= BRAKE_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/gtpc_step.sv =====
module gtpc_step import gtpc_pkg::*; (
  input  cfg_t      cfg,
  input  state_t    st,
  input  in_item_t  item,
  output state_t    st_nxt,
  output out_item_t result
);

  localparam int EW = HEADING_BITS + 2;  // error width
  localparam int PW = EW + 11;           // product width

  logic signed [HEADING_BITS:0]   sp_ext;
  logic signed [HEADING_BITS:0]   sp_tgt;
  logic signed [EW-1:0]           hd_ext;
  logic signed [EW-1:0]           err_start;
  logic        [EW-1:0]           err_mag;
  logic [9:0]                     gain_sel;
  logic signed [EW-1:0]           err;
  logic signed [PW-1:0]           prod;
  logic signed [PW-1:0]           prod_adj;
  logic signed [PW-1:0]           speed_full;
  logic signed [8:0]              speed_clamp;
  logic signed [8:0]              kc;
  logic signed [8:0]              speed;
  logic                           done;
  logic signed [7:0]              brake_b;
  logic [7:0]                     rem_dec;
  logic                           fin;

  // Target and start error for a start item.
  always_comb begin
    sp_ext    = $signed({item.setpoint[HEADING_BITS-1], item.setpoint});
    sp_tgt    = cfg.mirror_turn ? -sp_ext : sp_ext;
    hd_ext    = $signed({{2{item.heading[HEADING_BITS-1]}}, item.heading});
    err_start = $signed({sp_tgt[HEADING_BITS], sp_tgt}) - hd_ext;
    err_mag   = err_start[EW-1] ? (-err_start) : err_start;
  end

  // Gain schedule from the start error magnitude.
  always_comb begin
    if (err_mag > EW'(ERR_LIMIT_HIGH)) begin
      gain_sel = GAIN_0P8;
    end else if (err_mag > EW'(ERR_LIMIT_MID)) begin
      gain_sel = GAIN_1P2;
    end else if (err_mag > EW'(ERR_LIMIT_LOW)) begin
      gain_sel = GAIN_1P8;
    end else begin
      gain_sel = GAIN_3P5;
    end
  end

  // Drive: error x gain, truncated toward zero, clamped, min-drive floor.
  always_comb begin
    err        = $signed({st.target[HEADING_BITS], st.target}) - hd_ext;
    prod       = PW'(err) * $signed({{(PW-10){1'b0}}, st.gain_q8});
    prod_adj   = prod[PW-1] ? (prod + PW'(255)) : prod;
    speed_full = prod_adj >>> 8;
    if (speed_full > PW'(DRIVE_MAX)) begin
      speed_clamp = 9'(DRIVE_MAX);
    end else if (speed_full < -PW'(DRIVE_MAX)) begin
      speed_clamp = -9'(DRIVE_MAX);
    end else begin
      speed_clamp = speed_full[8:0];
    end
    kc    = $signed({2'b00, cfg.min_drive});
    speed = speed_clamp;
    if (!st.turn_clockwise && (speed_clamp < kc)) begin
      speed = kc;
    end
    if (st.turn_clockwise && (speed_clamp > -kc)) begin
      speed = -kc;
    end
    done    = st.turn_clockwise ? !err[EW-1] : (err[EW-1] || (err == '0));
    brake_b = st.turn_clockwise ? -$signed({1'b0, cfg.brake_drive})
                                : $signed({1'b0, cfg.brake_drive});
    rem_dec = st.brake_remaining - 8'd1;
  end

  // State update for the item's command.
  always_comb begin
    st_nxt = st;
    fin    = 1'b0;
    case (item.command)
      CMD_START: begin
        st_nxt.target          = sp_tgt;
        st_nxt.gain_q8         = gain_sel;
        st_nxt.turn_clockwise  = err_start[EW-1];
        st_nxt.phase           = PH_TURN;
        st_nxt.brake_remaining = 8'd0;
        st_nxt.left_hold       = 8'sd0;
        st_nxt.right_hold      = 8'sd0;
      end
      CMD_SAMPLE: begin
        if (st.phase == PH_TURN) begin
          if (done) begin
            if (cfg.brake_ticks == 8'd0) begin
              st_nxt.phase      = PH_IDLE;
              st_nxt.left_hold  = 8'sd0;
              st_nxt.right_hold = 8'sd0;
              fin               = 1'b1;
            end else begin
              st_nxt.phase           = PH_BRAKE;
              st_nxt.brake_remaining = cfg.brake_ticks;
              st_nxt.left_hold       = brake_b;
              st_nxt.right_hold      = -brake_b;
            end
          end else begin
            st_nxt.left_hold  = -speed[7:0];
            st_nxt.right_hold = speed[7:0];
          end
        end
      end
      CMD_TICK: begin
        if (st.phase == PH_BRAKE) begin
          st_nxt.brake_remaining = rem_dec;
          if (rem_dec == 8'd0) begin
            st_nxt.phase      = PH_IDLE;
            st_nxt.left_hold  = 8'sd0;
            st_nxt.right_hold = 8'sd0;
            fin               = 1'b1;
          end
        end
      end
      default: st_nxt = st;
    endcase
  end

  // Result follows the updated hold registers.
  always_comb begin
    result.left_drive  = st_nxt.left_hold;
    result.right_drive = st_nxt.right_hold;
    result.busy_res    = (st_nxt.phase != PH_IDLE);
    result.finished    = fin;
  end

endmodule
